### sv/fog_reveal_region_marker_defines.svh
// assertion macros shared by the fog reveal region marker rtl
`ifndef FOG_REVEAL_REGION_MARKER_DEFINES_SVH
`define FOG_REVEAL_REGION_MARKER_DEFINES_SVH

// condition holds at every clock edge out of reset
`define FRRM_ASSERT_ALWAYS(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
        else $error("%m: invariant failed");

// consequent holds in the same cycle as the antecedent
`define FRRM_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: implication failed");

// consequent holds in the cycle after the antecedent
`define FRRM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

### sv/frrm_pkg.sv
// types and constants of the fog reveal region marker
`default_nettype none

package frrm_pkg;

    localparam int MAP_COLS_DEFAULT   = 96;
    localparam int MAP_ROWS_DEFAULT   = 96;
    localparam int LIST_DEPTH_DEFAULT = 80;

    localparam int COORD_W = 8;
    localparam int COUNT_W = 7;
    localparam int SPAN_W  = COORD_W + 2;

    localparam logic REG_IDX_ALL_REVEALED = 1'b0;

    typedef enum logic [1:0] {
        MODE_REVEAL = 2'd0,
        MODE_RESET  = 2'd1,
        MODE_QUERY  = 2'd2,
        MODE_READ   = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_REV_ROW,
        ST_REV_LOAD,
        ST_REV_WALK,
        ST_REV_WB,
        ST_Q_DATA,
        ST_L_DATA,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

### sv/frrm_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none

module frrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### sv/fog_reveal_region_marker.sv
// fog reveal region marker: explored row map and newly revealed tile list
// query and list read: accept, then ST_Q_DATA or ST_L_DATA, then ST_DONE registers the result
// reveal: per row ST_REV_ROW, ST_REV_LOAD, ST_REV_WALK over each tile in span, ST_REV_WB
// map reset op: ST_CLEAR, one map row written per cycle, then ST_DONE
// aresetn: clears control state then sweeps every map row in ST_INIT, s_tready low
// one transaction in flight; a new one is taken while the last result waits on m_tready
`default_nettype none

`include "fog_reveal_region_marker_defines.svh"

module fog_reveal_region_marker
    import frrm_pkg::*;
#(
    parameter int MAP_COLS   = MAP_COLS_DEFAULT,
    parameter int MAP_ROWS   = MAP_ROWS_DEFAULT,
    parameter int LIST_DEPTH = LIST_DEPTH_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    // col[7:0], row[15:8], radius[23:16], entry_index[31:24]
    input  wire logic [31:0] s_tdata,
    // mode[1:0]
    input  wire logic [1:0]  s_tuser,

    output logic             m_tvalid,
    input  wire logic        m_tready,
    // revealed[0], entry_col[8:1], entry_row[16:9], entry_count[23:17],
    // list_overflow[24], zero[31:25]
    output logic [31:0]      m_tdata,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int RAW  = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;
    localparam int CAW  = (MAP_COLS > 1) ? $clog2(MAP_COLS) : 1;
    localparam int LAW  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNTW = $clog2(LIST_DEPTH + 1);

    localparam logic signed [SPAN_W-1:0] COL_LAST = SPAN_W'(MAP_COLS - 1);
    localparam logic signed [SPAN_W-1:0] ROW_LAST = SPAN_W'(MAP_ROWS - 1);
    localparam logic [COORD_W-1:0]       ROW_END  = COORD_W'(MAP_ROWS - 1);
    localparam logic [CNTW-1:0]          LIST_MAX = CNTW'(LIST_DEPTH);

    // input fields
    mode_t              in_mode;
    logic [COORD_W-1:0] in_col, in_row, in_rad, in_ei;

    assign in_mode = mode_t'(s_tuser);
    assign in_col  = s_tdata[7:0];
    assign in_row  = s_tdata[15:8];
    assign in_rad  = s_tdata[23:16];
    assign in_ei   = s_tdata[31:24];

    // registers
    state_t              state_reg, state_next;
    logic                all_rev_reg;
    logic [CNTW-1:0]     cnt_reg, cnt_next;
    logic                ovf_reg, ovf_next;
    logic [COORD_W-1:0]  clr_reg, clr_next;
    logic [COORD_W-1:0]  x_reg, x_next;
    logic [COORD_W-1:0]  xe_reg, xe_next;
    logic [COORD_W-1:0]  y_reg, y_next;
    logic [COORD_W-1:0]  min_x_reg, min_x_next;
    logic [COORD_W-1:0]  max_x_reg, max_x_next;
    logic [COORD_W-1:0]  max_y_reg, max_y_next;
    logic signed [SPAN_W-1:0] top_reg, top_next;
    logic signed [SPAN_W-1:0] bot_reg, bot_next;
    logic                rad_nz_reg, rad_nz_next;
    logic [COORD_W-1:0]  qcol_reg, qcol_next;
    logic [MAP_COLS-1:0] line_reg, line_next;
    logic                pend_rev_reg, pend_rev_next;
    logic [COORD_W-1:0]  pend_ec_reg, pend_ec_next;
    logic [COORD_W-1:0]  pend_er_reg, pend_er_next;
    logic                m_valid_reg, m_valid_next;
    logic                o_rev_reg, o_rev_next;
    logic [COORD_W-1:0]  o_ec_reg, o_ec_next;
    logic [COORD_W-1:0]  o_er_reg, o_er_next;
    logic [COUNT_W-1:0]  o_cnt_reg, o_cnt_next;
    logic                o_ovf_reg, o_ovf_next;

    // memory ports
    logic                map_we, map_re;
    logic [RAW-1:0]      map_waddr, map_raddr;
    logic [MAP_COLS-1:0] map_wdata, map_rdata;
    logic                lst_we, lst_re;
    logic [LAW-1:0]      lst_waddr, lst_raddr;
    logic [2*COORD_W-1:0] lst_wdata, lst_rdata;

    frrm_ram #(
        .WIDTH (MAP_COLS),
        .DEPTH (MAP_ROWS)
    ) u_map_ram (
        .aclk  (aclk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .re    (map_re),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    frrm_ram #(
        .WIDTH (2 * COORD_W),
        .DEPTH (LIST_DEPTH)
    ) u_list_ram (
        .aclk  (aclk),
        .we    (lst_we),
        .waddr (lst_waddr),
        .wdata (lst_wdata),
        .re    (lst_re),
        .raddr (lst_raddr),
        .rdata (lst_rdata)
    );

    // configuration port
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_IDX_ALL_REVEALED);
    assign prdata = (paddr[2] == REG_IDX_ALL_REVEALED) ? {31'b0, all_rev_reg} : 32'b0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            all_rev_reg <= 1'b0;
        end else if (cfg_wr) begin
            all_rev_reg <= pwdata[0];
        end
    end

    // reveal window, clipped to the map
    logic signed [SPAN_W-1:0] lo_x, hi_x, lo_y, hi_y;
    logic [COORD_W-1:0]       min_x_in, max_x_in, min_y_in, max_y_in;

    assign lo_x = $signed({2'b00, in_col}) - $signed({2'b00, in_rad});
    assign hi_x = $signed({2'b00, in_col}) + $signed({2'b00, in_rad});
    assign lo_y = $signed({2'b00, in_row}) - $signed({2'b00, in_rad});
    assign hi_y = $signed({2'b00, in_row}) + $signed({2'b00, in_rad});

    assign min_x_in = (lo_x < 0) ? '0 : lo_x[COORD_W-1:0];
    assign max_x_in = (hi_x > COL_LAST) ? COL_LAST[COORD_W-1:0] : hi_x[COORD_W-1:0];
    assign min_y_in = (lo_y < 0) ? '0 : lo_y[COORD_W-1:0];
    assign max_y_in = (hi_y > ROW_LAST) ? ROW_LAST[COORD_W-1:0] : hi_y[COORD_W-1:0];

    // current row span, narrowed on the unclipped top and bottom rows
    logic                 row_edge, span_ok, tile_set, list_room;
    logic [COORD_W:0]     span_hi;
    logic [COORD_W-1:0]   xs_row, xe_row;

    assign row_edge  = rad_nz_reg && ($signed({2'b00, y_reg}) == top_reg ||
                                      $signed({2'b00, y_reg}) == bot_reg);
    assign span_hi   = {1'b0, max_x_reg};
    assign span_ok   = row_edge ? (({1'b0, min_x_reg} + (COORD_W+1)'(2)) <= span_hi)
                                : (min_x_reg <= max_x_reg);
    assign xs_row    = min_x_reg + COORD_W'(row_edge);
    assign xe_row    = max_x_reg - COORD_W'(row_edge);
    assign tile_set  = line_reg[x_reg[CAW-1:0]];
    assign list_room = cnt_reg < LIST_MAX;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        ovf_next      = ovf_reg;
        clr_next      = clr_reg;
        x_next        = x_reg;
        xe_next       = xe_reg;
        y_next        = y_reg;
        min_x_next    = min_x_reg;
        max_x_next    = max_x_reg;
        max_y_next    = max_y_reg;
        top_next      = top_reg;
        bot_next      = bot_reg;
        rad_nz_next   = rad_nz_reg;
        qcol_next     = qcol_reg;
        line_next     = line_reg;
        pend_rev_next = pend_rev_reg;
        pend_ec_next  = pend_ec_reg;
        pend_er_next  = pend_er_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        o_rev_next    = o_rev_reg;
        o_ec_next     = o_ec_reg;
        o_er_next     = o_er_reg;
        o_cnt_next    = o_cnt_reg;
        o_ovf_next    = o_ovf_reg;

        map_we    = 1'b0;
        map_waddr = y_reg[RAW-1:0];
        map_wdata = line_reg;
        map_re    = 1'b0;
        map_raddr = y_reg[RAW-1:0];
        lst_we    = 1'b0;
        lst_waddr = cnt_reg[LAW-1:0];
        lst_wdata = {y_reg, x_reg};
        lst_re    = 1'b0;
        lst_raddr = in_ei[LAW-1:0];

        case (state_reg)
            ST_INIT, ST_CLEAR: begin
                map_we    = 1'b1;
                map_waddr = clr_reg[RAW-1:0];
                map_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == ROW_END) begin
                    clr_next   = '0;
                    state_next = (state_reg == ST_INIT) ? ST_IDLE : ST_DONE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    pend_rev_next = 1'b0;
                    pend_ec_next  = '0;
                    pend_er_next  = '0;
                    qcol_next     = in_col;
                    state_next    = ST_DONE;
                    case (in_mode)
                        MODE_REVEAL: begin
                            cnt_next    = '0;
                            ovf_next    = 1'b0;
                            min_x_next  = min_x_in;
                            max_x_next  = max_x_in;
                            max_y_next  = max_y_in;
                            y_next      = min_y_in;
                            top_next    = lo_y;
                            bot_next    = hi_y;
                            rad_nz_next = (in_rad != '0);
                            if (min_y_in <= max_y_in) begin
                                state_next = ST_REV_ROW;
                            end
                        end
                        MODE_RESET: begin
                            cnt_next = '0;
                            ovf_next = 1'b0;
                            if (!all_rev_reg) begin
                                state_next = ST_CLEAR;
                            end
                        end
                        MODE_QUERY: begin
                            if (all_rev_reg) begin
                                pend_rev_next = 1'b1;
                            end else if ((9'(in_col) < 9'(MAP_COLS)) &&
                                         (9'(in_row) < 9'(MAP_ROWS))) begin
                                map_re     = 1'b1;
                                map_raddr  = in_row[RAW-1:0];
                                state_next = ST_Q_DATA;
                            end
                        end
                        MODE_READ: begin
                            if (9'(in_ei) < 9'(cnt_reg)) begin
                                lst_re     = 1'b1;
                                state_next = ST_L_DATA;
                            end
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_REV_ROW: begin
                x_next  = xs_row;
                xe_next = xe_row;
                if (span_ok) begin
                    map_re     = 1'b1;
                    state_next = ST_REV_LOAD;
                end else if (y_reg == max_y_reg) begin
                    state_next = ST_DONE;
                end else begin
                    y_next = y_reg + 1'b1;
                end
            end
            ST_REV_LOAD: begin
                line_next  = map_rdata;
                state_next = ST_REV_WALK;
            end
            ST_REV_WALK: begin
                if (!tile_set) begin
                    line_next[x_reg[CAW-1:0]] = 1'b1;
                    if (list_room) begin
                        lst_we   = 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                    end else begin
                        ovf_next = 1'b1;
                    end
                end
                if (x_reg == xe_reg) begin
                    state_next = ST_REV_WB;
                end else begin
                    x_next = x_reg + 1'b1;
                end
            end
            ST_REV_WB: begin
                map_we = 1'b1;
                if (y_reg == max_y_reg) begin
                    state_next = ST_DONE;
                end else begin
                    y_next     = y_reg + 1'b1;
                    state_next = ST_REV_ROW;
                end
            end
            ST_Q_DATA: begin
                pend_rev_next = map_rdata[qcol_reg[CAW-1:0]];
                state_next    = ST_DONE;
            end
            ST_L_DATA: begin
                pend_ec_next = lst_rdata[COORD_W-1:0];
                pend_er_next = lst_rdata[2*COORD_W-1:COORD_W];
                state_next   = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    o_rev_next   = pend_rev_reg;
                    o_ec_next    = pend_ec_reg;
                    o_er_next    = pend_er_reg;
                    o_cnt_next   = COUNT_W'(cnt_reg);
                    o_ovf_next   = ovf_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            cnt_reg     <= '0;
            ovf_reg     <= 1'b0;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            ovf_reg     <= ovf_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg        <= x_next;
        xe_reg       <= xe_next;
        y_reg        <= y_next;
        min_x_reg    <= min_x_next;
        max_x_reg    <= max_x_next;
        max_y_reg    <= max_y_next;
        top_reg      <= top_next;
        bot_reg      <= bot_next;
        rad_nz_reg   <= rad_nz_next;
        qcol_reg     <= qcol_next;
        line_reg     <= line_next;
        pend_rev_reg <= pend_rev_next;
        pend_ec_reg  <= pend_ec_next;
        pend_er_reg  <= pend_er_next;
        o_rev_reg    <= o_rev_next;
        o_ec_reg     <= o_ec_next;
        o_er_reg     <= o_er_next;
        o_cnt_reg    <= o_cnt_next;
        o_ovf_reg    <= o_ovf_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, o_ovf_reg, o_cnt_reg, o_er_reg, o_ec_reg, o_rev_reg};

    `FRRM_ASSERT_ALWAYS(a_cnt_bound, aclk, aresetn, cnt_reg <= LIST_MAX)
    `FRRM_ASSERT_IMPLY(a_ovf_full, aclk, aresetn, ovf_reg, cnt_reg == LIST_MAX)
    `FRRM_ASSERT_IMPLY(a_walk_span, aclk, aresetn, state_reg == ST_REV_WALK, x_reg <= xe_reg)
    `FRRM_ASSERT_NEXT(a_reveal_empties, aclk, aresetn,
        s_tvalid && s_tready && s_tuser == MODE_REVEAL, cnt_reg == '0 && !ovf_reg)

endmodule

`default_nettype wire
